[hdl/btop_pkg.sv]
package btop_pkg;

    localparam int MAX_STEPS = 1024;
    localparam int IDX_W = $clog2(MAX_STEPS + 1);
    localparam int CFG_IDX_W = 3;
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UP_PROB = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIKE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IS_CALL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EARLY_EX = 3'd7;

    typedef enum logic [1:0] {
        VOP_NONE,
        VOP_P,
        VOP_Q,
        VOP_D
    } vop_t;

    typedef struct packed {
        logic [10:0] step_count;
        logic [31:0] up_factor;
        logic [30:0] down_factor;
        logic [31:0] up_probability;
        logic [31:0] step_discount;
        logic [31:0] strike_price;
        logic        is_call;
        logic        early_exercise;
    } cfg_t;

    typedef struct packed {
        logic             load_spot;
        logic             mul_en;
        logic             mul_up;
        logic             s_upd;
        logic             row_cap;
        logic             p_we;
        logic             p_rd;
        logic             v_rd;
        logic             v_leaf_we;
        logic             v_node_we;
        logic             vhi_cap;
        vop_t             vop;
        logic             acc_ld;
        logic             mix_ld;
        logic [IDX_W-1:0] pa;
        logic [IDX_W-1:0] va;
    } cmd_t;

endpackage

[hdl/btop_datapath.sv]
module btop_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  btop_pkg::cfg_t   cfg,
    input  btop_pkg::cmd_t   cmd,
    input  logic [31:0]      spot_price,
    output logic [31:0]      result,
    output logic             sat
);
    import btop_pkg::*;

    logic [31:0] pmem [0:MAX_STEPS];
    logic [31:0] vmem [0:MAX_STEPS];

    logic [31:0] prdata_reg;
    logic [31:0] vrdata_reg;
    logic [31:0] s_reg;
    logic [63:0] pprod_reg;
    logic [63:0] vprod_reg;
    logic [63:0] acc_reg;
    logic [31:0] mix_reg;
    logic [31:0] vlo_reg;
    logic [31:0] vhi_reg;
    logic [31:0] res_reg;
    logic        sat_reg;

    logic [31:0] p_eff;
    logic [31:0] q_eff;
    logic [31:0] d_eff;
    logic [31:0] s_next;
    logic        s_ovf;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] pmul_f;
    logic [63:0] mix_sum;
    logic [31:0] cont;
    logic [31:0] ex_s;
    logic [31:0] ex_leaf;
    logic [31:0] node_v;
    logic [31:0] leaf_v;

    function automatic logic [31:0] exercise(input logic [31:0] s, input logic [31:0] k,
                                             input logic call);
        logic [31:0] r;
        r = 32'd0;
        if (call)
        begin
            if (s > k)
            begin
                r = s - k;
            end
        end
        else if (k > s)
        begin
            r = k - s;
        end
        return r;
    endfunction

    assign p_eff = (cfg.up_probability > ONE_Q31) ? ONE_Q31 : cfg.up_probability;
    assign q_eff = ONE_Q31 - p_eff;
    assign d_eff = (cfg.step_discount > ONE_Q31) ? ONE_Q31 : cfg.step_discount;
    assign pmul_f = cmd.mul_up ? cfg.up_factor : {1'b0, cfg.down_factor};
    assign s_ovf = |pprod_reg[63:62];
    assign s_next = s_ovf ? 32'hFFFF_FFFF : pprod_reg[61:30];
    assign mix_sum = acc_reg + vprod_reg;
    assign cont = vprod_reg[62:31];
    assign ex_s = exercise(s_reg, cfg.strike_price, cfg.is_call);
    assign leaf_v = ex_s;
    assign ex_leaf = ex_s;
    assign node_v = (cfg.early_exercise && (ex_leaf > cont)) ? ex_leaf : cont;

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (cmd.vop)
            VOP_P:
            begin
                mul_a = p_eff;
                mul_b = vrdata_reg;
            end
            VOP_Q:
            begin
                mul_a = q_eff;
                mul_b = vlo_reg;
            end
            VOP_D:
            begin
                mul_a = d_eff;
                mul_b = mix_reg;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.p_we)
        begin
            pmem[cmd.pa] <= cmd.load_spot ? spot_price : s_next;
        end
        if (cmd.p_rd)
        begin
            prdata_reg <= pmem[cmd.pa];
        end
        if (cmd.v_leaf_we)
        begin
            vmem[cmd.va] <= leaf_v;
        end
        else if (cmd.v_node_we)
        begin
            vmem[cmd.va] <= node_v;
        end
        if (cmd.v_rd)
        begin
            vrdata_reg <= vmem[cmd.va];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_spot)
        begin
            s_reg <= spot_price;
        end
        else if (cmd.s_upd)
        begin
            s_reg <= s_next;
        end
        else if (cmd.row_cap)
        begin
            s_reg <= prdata_reg;
        end
        if (cmd.mul_en)
        begin
            pprod_reg <= 64'(s_reg) * 64'(pmul_f);
        end
        if (cmd.vop != VOP_NONE)
        begin
            vprod_reg <= 64'(mul_a) * 64'(mul_b);
        end
        if (cmd.acc_ld)
        begin
            acc_reg <= vprod_reg;
        end
        if (cmd.mix_ld)
        begin
            mix_reg <= mix_sum[62:31];
        end
        if (cmd.row_cap)
        begin
            vlo_reg <= vrdata_reg;
        end
        else if (cmd.v_node_we)
        begin
            vlo_reg <= vhi_reg;
        end
        if (cmd.vhi_cap)
        begin
            vhi_reg <= vrdata_reg;
        end
        if (cmd.v_node_we)
        begin
            res_reg <= node_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
        end
        else if (cmd.load_spot)
        begin
            sat_reg <= 1'b0;
        end
        else if (cmd.s_upd && s_ovf)
        begin
            sat_reg <= 1'b1;
        end
    end

    assign result = res_reg;
    assign sat = sat_reg;

endmodule

[hdl/btop_ctrl.sv]
module btop_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [10:0]                step_count,
    output btop_pkg::cmd_t             cmd,
    output logic                       busy,
    output logic                       done
);
    import btop_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE_M,
        S_BASE_W,
        S_LEAF_W,
        S_LEAF_M,
        S_LEAF_S,
        S_ROW_RD,
        S_ROW_CAP,
        S_N_RD,
        S_N_M1,
        S_N_M2,
        S_N_M3,
        S_N_M4,
        S_N_WR
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] n_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [IDX_W-1:0] n_eff;
    logic             accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        if (step_count == 11'd0)
        begin
            n_eff = IDX_W'(1);
        end
        else if (32'(step_count) > MAX_STEPS)
        begin
            n_eff = IDX_W'(MAX_STEPS);
        end
        else
        begin
            n_eff = IDX_W'(step_count);
        end
    end

    always_comb
    begin
        cmd = '0;
        cmd.vop = VOP_NONE;
        cmd.pa = i_reg;
        cmd.va = j_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_spot = accept;
                cmd.p_we = accept;
                cmd.pa = '0;
            end
            S_BASE_M:
            begin
                cmd.mul_en = 1'b1;
            end
            S_BASE_W:
            begin
                cmd.s_upd = 1'b1;
                cmd.p_we = 1'b1;
            end
            S_LEAF_W:
            begin
                cmd.v_leaf_we = 1'b1;
            end
            S_LEAF_M:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_up = 1'b1;
            end
            S_LEAF_S:
            begin
                cmd.s_upd = 1'b1;
            end
            S_ROW_RD:
            begin
                cmd.p_rd = 1'b1;
                cmd.v_rd = 1'b1;
                cmd.va = '0;
            end
            S_ROW_CAP:
            begin
                cmd.row_cap = 1'b1;
            end
            S_N_RD:
            begin
                cmd.v_rd = 1'b1;
                cmd.va = j_reg + IDX_W'(1);
                cmd.mul_en = (j_reg != '0);
                cmd.mul_up = 1'b1;
            end
            S_N_M1:
            begin
                cmd.vhi_cap = 1'b1;
                cmd.vop = VOP_P;
                cmd.s_upd = (j_reg != '0);
            end
            S_N_M2:
            begin
                cmd.acc_ld = 1'b1;
                cmd.vop = VOP_Q;
            end
            S_N_M3:
            begin
                cmd.mix_ld = 1'b1;
            end
            S_N_M4:
            begin
                cmd.vop = VOP_D;
            end
            S_N_WR:
            begin
                cmd.v_node_we = 1'b1;
            end
            default:
            begin
                cmd.vop = VOP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        n_reg <= n_eff;
                        i_reg <= IDX_W'(1);
                        busy_reg <= 1'b1;
                        state_reg <= S_BASE_M;
                    end
                end
                S_BASE_M:
                begin
                    state_reg <= S_BASE_W;
                end
                S_BASE_W:
                begin
                    if (i_reg == n_reg)
                    begin
                        j_reg <= '0;
                        state_reg <= S_LEAF_W;
                    end
                    else
                    begin
                        i_reg <= i_reg + IDX_W'(1);
                        state_reg <= S_BASE_M;
                    end
                end
                S_LEAF_W:
                begin
                    if (j_reg == n_reg)
                    begin
                        i_reg <= n_reg - IDX_W'(1);
                        state_reg <= S_ROW_RD;
                    end
                    else
                    begin
                        j_reg <= j_reg + IDX_W'(1);
                        state_reg <= S_LEAF_M;
                    end
                end
                S_LEAF_M:
                begin
                    state_reg <= S_LEAF_S;
                end
                S_LEAF_S:
                begin
                    state_reg <= S_LEAF_W;
                end
                S_ROW_RD:
                begin
                    j_reg <= '0;
                    state_reg <= S_ROW_CAP;
                end
                S_ROW_CAP:
                begin
                    state_reg <= S_N_RD;
                end
                S_N_RD:
                begin
                    state_reg <= S_N_M1;
                end
                S_N_M1:
                begin
                    state_reg <= S_N_M2;
                end
                S_N_M2:
                begin
                    state_reg <= S_N_M3;
                end
                S_N_M3:
                begin
                    state_reg <= S_N_M4;
                end
                S_N_M4:
                begin
                    state_reg <= S_N_WR;
                end
                S_N_WR:
                begin
                    if (j_reg == i_reg)
                    begin
                        if (i_reg == '0)
                        begin
                            done_reg <= 1'b1;
                            busy_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg <= i_reg - IDX_W'(1);
                            state_reg <= S_ROW_RD;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + IDX_W'(1);
                        state_reg <= S_N_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("Result strobe while busy.");
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("Accepted item did not raise busy.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_N_WR) |-> (j_reg <= i_reg && i_reg < n_reg))
        else $error("Node index outside the current row.");
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (n_reg != '0 && 32'(n_reg) <= MAX_STEPS))
        else $error("Step count out of range while busy.");

endmodule

[hdl/binomial_tree_option_pricer_core.sv]
// Binomial lattice option pricer.
// Configuration is written through cfg_we, cfg_index and cfg_data, one register per
// clock edge. The user must write only while busy is low; the block does not enforce
// this. Register indexes follow the register list: step count, up factor, down factor,
// up probability, discount, strike, call, American. An item is accepted at a clock
// edge where start is high and busy is low; spot_price is sampled at that edge. busy
// then stays high until the result is delivered. The result appears on option_value
// and saturated, marked by done for exactly one cycle; the receiver cannot stall, so
// it must take the item in that cycle. Per item the controller computes the row bases,
// then the leaves, then each induction node in a read, multiply and write sequence set
// by the value multiplier and the single read port of the node value memory.
// A new item may be started in the cycle done is shown.
// Reset restores the register defaults and aborts any item in progress; the node
// memories need no clearing since every entry is written before it is read.
module binomial_tree_option_pricer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [31:0]                        spot_price,
    output logic                               done,
    output logic [31:0]                        option_value,
    output logic                               saturated,
    input  logic                               cfg_we,
    input  logic [btop_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);
    import btop_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_count <= 11'd64;
            cfg_reg.up_factor <= 32'h4000_0000;
            cfg_reg.down_factor <= 31'h4000_0000;
            cfg_reg.up_probability <= 32'h4000_0000;
            cfg_reg.step_discount <= 32'h8000_0000;
            cfg_reg.strike_price <= 32'd0;
            cfg_reg.is_call <= 1'b1;
            cfg_reg.early_exercise <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_COUNT: cfg_reg.step_count <= cfg_data[10:0];
                REG_UP_FACTOR: cfg_reg.up_factor <= cfg_data;
                REG_DOWN_FACTOR: cfg_reg.down_factor <= cfg_data[30:0];
                REG_UP_PROB: cfg_reg.up_probability <= cfg_data;
                REG_DISCOUNT: cfg_reg.step_discount <= cfg_data;
                REG_STRIKE: cfg_reg.strike_price <= cfg_data;
                REG_IS_CALL: cfg_reg.is_call <= cfg_data[0];
                REG_EARLY_EX: cfg_reg.early_exercise <= cfg_data[0];
                default: cfg_reg.is_call <= cfg_reg.is_call;
            endcase
        end
    end

    btop_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .step_count (cfg_reg.step_count),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    btop_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .spot_price (spot_price),
        .result     (option_value),
        .sat        (saturated)
    );

endmodule

[verif/binomial_tree_option_pricer_core_tb.sv]
`timescale 1ns / 1ps

module binomial_tree_option_pricer_core_tb;
    import btop_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] spot_price;
    logic        done;
    logic [31:0] option_value;
    logic        saturated;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    typedef struct {
        logic [31:0] value;
        logic        sat;
    } quote_t;

    quote_t expected_quotes[$];
    int     mismatch_count;
    bit     timed_out;

    logic [10:0] m_steps;
    logic [31:0] m_up;
    logic [30:0] m_down;
    logic [31:0] m_prob;
    logic [31:0] m_disc;
    logic [31:0] m_strike;
    logic        m_call;
    logic        m_american;

    logic [31:0] lattice_values [0:MAX_STEPS];
    logic [31:0] row_bases [0:MAX_STEPS];

    binomial_tree_option_pricer_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .spot_price(spot_price), .done(done), .option_value(option_value),
        .saturated(saturated), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [31:0] scale_by_factor(input logic [31:0] a,
                                                    input logic [31:0] f,
                                                    inout logic sat);
        logic [63:0] r;
        r = ({32'd0, a} * {32'd0, f}) >> 30;
        if (r > 64'hFFFF_FFFF)
        begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] payoff(input logic [31:0] s);
        if (m_call)
            return (s > m_strike) ? s - m_strike : 32'd0;
        return (m_strike > s) ? m_strike - s : 32'd0;
    endfunction

    function automatic quote_t price_option(input logic [31:0] spot);
        int          n;
        logic [63:0] p, q, disc, mix, cont;
        logic [31:0] s, v, ex;
        logic        sat;
        quote_t      res;
        n = m_steps;
        if (n == 0)
            n = 1;
        if (n > MAX_STEPS)
            n = MAX_STEPS;
        p = {32'd0, m_prob};
        if (p > 64'h8000_0000)
            p = 64'h8000_0000;
        disc = {32'd0, m_disc};
        if (disc > 64'h8000_0000)
            disc = 64'h8000_0000;
        q = 64'h8000_0000 - p;
        sat = 1'b0;
        row_bases[0] = spot;
        for (int i = 1; i <= n; i++)
            row_bases[i] = scale_by_factor(row_bases[i-1], {1'b0, m_down}, sat);
        s = row_bases[n];
        for (int j = 0; j <= n; j++)
        begin
            if (j > 0)
                s = scale_by_factor(s, m_up, sat);
            lattice_values[j] = payoff(s);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            s = row_bases[i];
            for (int j = 0; j <= i; j++)
            begin
                if (j > 0)
                    s = scale_by_factor(s, m_up, sat);
                mix = (p * {32'd0, lattice_values[j+1]} + q * {32'd0, lattice_values[j]}) >> 31;
                cont = (disc * mix) >> 31;
                v = cont[31:0];
                if (m_american)
                begin
                    ex = payoff(s);
                    if (ex > v)
                        v = ex;
                end
                lattice_values[j] = v;
            end
        end
        res.value = lattice_values[0];
        res.sat = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        quote_t e;
        if (rst_n && done)
        begin
            if (expected_quotes.size() == 0)
                report_mismatch("unexpected result", option_value, 32'd0);
            else
            begin
                e = expected_quotes.pop_front();
                if (option_value !== e.value)
                    report_mismatch("option_value", option_value, e.value);
                if (saturated !== e.sat)
                    report_mismatch("saturated", {31'd0, saturated}, {31'd0, e.sat});
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        case (idx)
            REG_STEP_COUNT:  m_steps = data[10:0];
            REG_UP_FACTOR:   m_up = data;
            REG_DOWN_FACTOR: m_down = data[30:0];
            REG_UP_PROB:     m_prob = data;
            REG_DISCOUNT:    m_disc = data;
            REG_STRIKE:      m_strike = data;
            REG_IS_CALL:     m_call = data[0];
            REG_EARLY_EX:    m_american = data[0];
            default:         ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_quotes.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic set_market(input int steps, input logic [31:0] up, input logic [31:0] dn,
                              input logic [31:0] prob, input logic [31:0] disc,
                              input logic [31:0] strike, input bit call, input bit amer);
        wait_idle();
        write_reg(REG_STEP_COUNT, 32'(steps));
        write_reg(REG_UP_FACTOR, up);
        write_reg(REG_DOWN_FACTOR, dn);
        write_reg(REG_UP_PROB, prob);
        write_reg(REG_DISCOUNT, disc);
        write_reg(REG_STRIKE, strike);
        write_reg(REG_IS_CALL, {31'd0, call});
        write_reg(REG_EARLY_EX, {31'd0, amer});
    endtask

    task automatic send_spot(input logic [31:0] spot);
        @(negedge clk);
        while (busy)
            @(negedge clk);
        start = 1'b1;
        spot_price = spot;
        expected_quotes.push_back(price_option(spot));
        @(negedge clk);
        start = 1'b0;
        spot_price = $urandom;
    endtask

    task automatic test_reset_defaults();
        m_steps = 11'd64; m_up = 32'h4000_0000; m_down = 31'h4000_0000;
        m_prob = 32'h4000_0000; m_disc = 32'h8000_0000; m_strike = 32'd0;
        m_call = 1'b1; m_american = 1'b1;
        send_spot(32'h0001_0000);
        send_spot(32'hFFFF_FFFF);
    endtask

    task automatic test_directed_extremes();
        set_market(4, 32'h4400_0000, 32'h3C00_0000, 32'h4000_0000, 32'h7F00_0000,
                   32'h0001_0000, 1'b1, 1'b1);
        send_spot(32'd0);
        send_spot(32'h0001_0000);
        send_spot(32'hFFFF_FFFF);
        set_market(4, 32'h4400_0000, 32'h3C00_0000, 32'h4000_0000, 32'h7F00_0000,
                   32'h0001_0000, 1'b0, 1'b0);
        send_spot(32'h0000_8000);
        send_spot(32'hFFFF_FFFF);
        set_market(0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   1'b0, 1'b1);
        send_spot(32'h1234_5678);
        send_spot(32'hFFFF_FFFF);
        set_market(1, 32'h4000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0);
        send_spot(32'hFFFF_FFFF);
        send_spot(32'h0002_0000);
        set_market(2047, 32'h4000_0000, 32'h4000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h0001_0000, 1'b1, 1'b0);
        send_spot(32'h0003_0000);
        set_market(MAX_STEPS, 32'h4010_0000, 32'h3FF0_0000, 32'h4100_0000, 32'h7FFF_0000,
                   32'h0064_0000, 1'b0, 1'b1);
        send_spot(32'h0064_0000);
    endtask

    task automatic test_random_quotes();
        int burst;
        for (int k = 0; k < 100; k += burst)
        begin
            if (k % 20 == 0)
                set_market($urandom_range(1, 24), $urandom_range(32'h4000_0000, 32'h5000_0000),
                           $urandom_range(32'h3000_0000, 32'h4000_0000),
                           ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h8000_0000),
                           ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h8000_0000),
                           $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            burst = $urandom_range(1, 5);
            for (int b = 0; b < burst; b++)
                send_spot(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF));
            repeat ($urandom_range(0, 6))
                @(negedge clk);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        spot_price = 32'd0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = 32'd0;
        mismatch_count = 0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_directed_extremes();
        test_random_quotes();
        wait_idle();
        repeat (20)
            @(negedge clk);
        if (mismatch_count == 0 && !timed_out)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        timed_out = 1'b0;
        #120_000_000;
        timed_out = 1'b1;
        $display("FAIL");
        $finish;
    end

endmodule

[binomial_tree_option_pricer_core.f]
hdl/btop_pkg.sv
hdl/btop_datapath.sv
hdl/btop_ctrl.sv
hdl/binomial_tree_option_pricer_core.sv
verif/binomial_tree_option_pricer_core_tb.sv
